FILE: src/rhp_pkg.sv
package rhp_pkg;

	// Default depth of the byte store
	localparam int unsigned BUFFER_BYTES_DEF = 256;

	// Most entries reported for one buffer
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned REM_W = $clog2(MAX_RESULTS + 1);

	// Request queue between the byte front and the parse engine
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	// Configuration register map
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_END_SIG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEGIN_SIG = 1'd1;

	// Reset values: ASCII "Rich" and "DanS" read little-endian
	localparam logic [31:0] END_SIG_RST = 32'h6863_6952;
	localparam logic [31:0] BEGIN_SIG_RST = 32'h536E_6144;

	localparam logic [31:0] HI_HALF_MASK = 32'hffff_0000;
	localparam logic [31:0] LO_HALF_MASK = 32'h0000_ffff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} rhp_in_t;

	typedef struct packed {
		logic [15:0] entry_id;
		logic [15:0] entry_build;
		logic [31:0] entry_uses;
		logic        entry_valid;
		logic        parse_error;
		logic        last_result;
	} rhp_out_t;

	typedef struct packed {
		logic [31:0] end_signature;
		logic [31:0] begin_signature;
	} rhp_cfg_t;

	// Byte request as classified by the front; the store address travels beside it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       store;
	} rhp_wr_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FIND,
		ST_CHECK,
		ST_KEY,
		ST_WALK,
		ST_SKIP,
		ST_COUNT,
		ST_ENT_A,
		ST_ENT_B,
		ST_ENT_OUT,
		ST_FLAG
	} rhp_state_t;

endpackage

FILE: src/rich_header_parser_unit.sv
// Bytes: one request per cycle while the four-deep request queue has room; the
// parse engine stores one a cycle while loading, none while parsing. After the
// last byte it scans each byte offset for the end mark, walks back by words, drops
// zero words, sets up, then emits each entry, waiting while the result is stalled.
// Parsing is bound by the single read port of the byte lanes. Reset clears control
// state and loads "Rich" / "DanS" into the signature registers; the store is not cleared.
module rich_header_parser_unit #(
	parameter int unsigned BUFFER_BYTES = rhp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rhp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  rhp_pkg::rhp_in_t                byte_req,
	output logic                            result_valid,
	input  logic                            result_stall,
	output rhp_pkg::rhp_out_t               result
);

	// Queue entry: store address beside the classified byte request
	localparam int unsigned QW = $clog2(BUFFER_BYTES) + $bits(rhp_pkg::rhp_wr_t);

	rhp_pkg::rhp_cfg_t cfg_q;
	logic              q_full;
	logic              push;
	logic [QW-1:0]     push_data;
	logic              pop;
	logic              q_valid;
	logic [QW-1:0]     q_data;

	// Hold the signature registers; write them only while the engine is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_signature <= rhp_pkg::END_SIG_RST;
			cfg_q.begin_signature <= rhp_pkg::BEGIN_SIG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rhp_pkg::REG_END_SIG: cfg_q.end_signature <= cfg_wdata;
				rhp_pkg::REG_BEGIN_SIG: cfg_q.begin_signature <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: count fill, mark overflow bytes to drop, push each request
	rhp_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_req(byte_req),
		.byte_stall(byte_stall),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	// Short queue lets bytes of the next buffer arrive while a table is parsed
	rhp_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.pop_valid(q_valid),
		.pop_data(q_data)
	);

	// Back: store bytes, then search, walk, skip and emit entries or a flag result from the store
	rhp_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

FILE: src/rhp_front.sv
module rhp_front #(
	parameter int unsigned BUFFER_BYTES = rhp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     byte_valid,
	input  rhp_pkg::rhp_in_t                                         byte_req,
	output logic                                                     byte_stall,
	input  logic                                                     q_full,
	output logic                                                     push,
	output logic [$clog2(BUFFER_BYTES)+$bits(rhp_pkg::rhp_wr_t)-1:0] push_data
);

	localparam int unsigned AddrW = $clog2(BUFFER_BYTES);
	localparam int unsigned SizeW = $clog2(BUFFER_BYTES + 1);

	logic [SizeW-1:0] fill_q;
	logic             store;
	rhp_pkg::rhp_wr_t wr;

	assign byte_stall = q_full;
	assign push = byte_valid && !q_full;

	// Drop bytes once the store is full; the last mark still goes through
	assign store = fill_q < SizeW'(BUFFER_BYTES);

	always_comb begin
		wr.data = byte_req.data_byte;
		wr.last = byte_req.last_byte;
		wr.store = store;
	end

	assign push_data = {fill_q[AddrW-1:0], wr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			if (byte_req.last_byte) begin
				fill_q <= '0;
			end else if (store) begin
				fill_q <= fill_q + SizeW'(1);
			end
		end
	end

endmodule

FILE: src/rhp_queue.sv
module rhp_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]           mem [rhp_pkg::QUEUE_DEPTH];
	logic [rhp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rhp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rhp_pkg::QPTR_W:0]   count_q;
	logic                       do_pop;

	assign full = count_q == (rhp_pkg::QPTR_W + 1)'(rhp_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem[rd_ptr_q];
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rhp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + rhp_pkg::QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + (rhp_pkg::QPTR_W + 1)'(1);
				2'b01: count_q <= count_q - (rhp_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/rhp_back.sv
module rhp_back #(
	parameter int unsigned BUFFER_BYTES = rhp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  rhp_pkg::rhp_cfg_t                                        cfg,
	input  logic                                                     q_valid,
	input  logic [$clog2(BUFFER_BYTES)+$bits(rhp_pkg::rhp_wr_t)-1:0] q_data,
	output logic                                                     pop,
	output logic                                                     result_valid,
	input  logic                                                     result_stall,
	output rhp_pkg::rhp_out_t                                        result
);

	localparam int unsigned WrW = $bits(rhp_pkg::rhp_wr_t);
	localparam int unsigned AddrW = $clog2(BUFFER_BYTES);
	localparam int unsigned SizeW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned BankDepth = (BUFFER_BYTES + 3) / 4;
	localparam int unsigned RowW = $clog2(BankDepth);
	localparam int unsigned PosW = RowW + 2;
	localparam int unsigned PW = SizeW + 1;
	localparam int unsigned RemW = rhp_pkg::REM_W;

	rhp_pkg::rhp_wr_t   wr;
	logic [AddrW-1:0]   wr_addr;
	logic [PosW-1:0]    wr_pos;
	logic               wr_en;

	rhp_pkg::rhp_state_t state_q, state_d;
	logic [PW-1:0]      size_q, size_d;
	logic [PW-1:0]      pos_q, pos_d;
	logic [PW-1:0]      found_q, found_d;
	logic [PW-1:0]      pad_q, pad_d;
	logic [PW-1:0]      cnt_q, cnt_d;
	logic [31:0]        key_q, key_d;
	logic [31:0]        a_q, a_d;
	logic [RemW-1:0]    rem_q, rem_d;
	logic               err_q, err_d;
	logic               out_vld_q, out_vld_d;
	rhp_pkg::rhp_out_t  out_q, out_d;

	logic               rd_en;
	logic [PW-1:0]      rd_pos;
	logic               rd_vld_q;
	logic [PW-1:0]      rd_pos_q;
	logic [3:0][7:0]    bank_rd;
	logic [31:0]        word;
	logic [31:0]        dec;
	logic               slot_free;
	logic [PW-1:0]      n_pairs;
	logic [PW-1:0]      n_bytes;

	assign wr = rhp_pkg::rhp_wr_t'(q_data[WrW-1:0]);
	assign wr_addr = q_data[WrW +: AddrW];
	assign wr_pos = PosW'(wr_addr);
	assign wr_en = pop && q_valid && wr.store;

	// Four byte lanes interleaved by address; any unaligned word is one row per lane
	for (genvar j = 0; j < 4; j++) begin : g_bank
		logic [7:0]      mem [BankDepth];
		logic [7:0]      rd_q;
		logic [1:0]      lane_ofs;
		logic [PosW-1:0] rd_addr;

		assign lane_ofs = 2'(j) - rd_pos[1:0];
		assign rd_addr = rd_pos[PosW-1:0] + PosW'(lane_ofs);
		assign bank_rd[j] = rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && wr_pos[1:0] == 2'(j)) begin
				mem[wr_pos[PosW-1:2]] <= wr.data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr[PosW-1:2]];
			end
		end
	end

	always_comb begin
		logic [1:0] lane;
		for (int k = 0; k < 4; k++) begin
			lane = rd_pos_q[1:0] + 2'(k);
			word[8*k +: 8] = bank_rd[lane];
		end
	end

	assign dec = word ^ key_q;
	assign slot_free = !out_vld_q || !result_stall;
	assign n_pairs = cnt_q >> 1;
	assign n_bytes = n_pairs << 3;

	always_comb begin
		state_d = state_q;
		size_d = size_q;
		pos_d = pos_q;
		found_d = found_q;
		pad_d = pad_q;
		cnt_d = cnt_q;
		key_d = key_q;
		a_d = a_q;
		rem_d = rem_q;
		err_d = err_q;
		out_d = out_q;
		out_vld_d = out_vld_q && result_stall;
		rd_en = 1'b0;
		rd_pos = pos_q;
		pop = 1'b0;

		case (state_q)
			rhp_pkg::ST_LOAD: begin
				pop = 1'b1;
				if (q_valid && wr.last) begin
					size_d = wr.store ? PW'(wr_addr) + PW'(1) : PW'(BUFFER_BYTES);
					pos_d = '0;
					state_d = rhp_pkg::ST_FIND;
				end
			end
			// Scan every byte offset for the end signature, one read per cycle
			rhp_pkg::ST_FIND: begin
				if (rd_vld_q && word == cfg.end_signature) begin
					found_d = rd_pos_q;
					state_d = rhp_pkg::ST_CHECK;
				end else if (pos_q + PW'(3) < size_q) begin
					rd_en = 1'b1;
					pos_d = pos_q + PW'(1);
				end else if (!rd_vld_q) begin
					err_d = 1'b1;
					state_d = rhp_pkg::ST_FLAG;
				end
			end
			rhp_pkg::ST_CHECK: begin
				if (found_q + PW'(8) > size_q || found_q < PW'(4)) begin
					err_d = 1'b1;
					state_d = rhp_pkg::ST_FLAG;
				end else begin
					rd_en = 1'b1;
					rd_pos = found_q + PW'(4);
					state_d = rhp_pkg::ST_KEY;
				end
			end
			rhp_pkg::ST_KEY: begin
				key_d = word;
				pos_d = found_q - PW'(4);
				pad_d = '0;
				state_d = rhp_pkg::ST_WALK;
			end
			// Walk down in words toward offset four looking for the begin mark
			rhp_pkg::ST_WALK: begin
				if (rd_vld_q && dec == cfg.begin_signature) begin
					pos_d = rd_pos_q + PW'(4);
					cnt_d = pad_q;
					state_d = rhp_pkg::ST_SKIP;
				end else begin
					if (rd_vld_q) begin
						pad_d = pad_q + PW'(1);
					end
					if (pos_q >= PW'(4)) begin
						rd_en = 1'b1;
						pos_d = pos_q - PW'(4);
					end else if (!rd_vld_q) begin
						err_d = 1'b1;
						state_d = rhp_pkg::ST_FLAG;
					end
				end
			end
			// Drop leading zero words above the begin mark
			rhp_pkg::ST_SKIP: begin
				if (rd_vld_q && dec != '0) begin
					state_d = rhp_pkg::ST_COUNT;
				end else begin
					if (rd_vld_q) begin
						cnt_d = cnt_q - PW'(1);
					end
					if (pos_q < found_q) begin
						rd_en = 1'b1;
						pos_d = pos_q + PW'(4);
					end else if (!rd_vld_q) begin
						state_d = rhp_pkg::ST_COUNT;
					end
				end
			end
			rhp_pkg::ST_COUNT: begin
				if (n_pairs == '0) begin
					err_d = 1'b0;
					state_d = rhp_pkg::ST_FLAG;
				end else begin
					rem_d = (n_pairs > PW'(rhp_pkg::MAX_RESULTS)) ?
						RemW'(rhp_pkg::MAX_RESULTS) : n_pairs[RemW-1:0];
					pos_d = found_q - n_bytes;
					state_d = rhp_pkg::ST_ENT_A;
				end
			end
			rhp_pkg::ST_ENT_A: begin
				rd_en = 1'b1;
				state_d = rhp_pkg::ST_ENT_B;
			end
			rhp_pkg::ST_ENT_B: begin
				a_d = dec;
				rd_en = 1'b1;
				rd_pos = pos_q + PW'(4);
				state_d = rhp_pkg::ST_ENT_OUT;
			end
			rhp_pkg::ST_ENT_OUT: begin
				if (slot_free) begin
					out_vld_d = 1'b1;
					out_d.entry_id = 16'((a_q & rhp_pkg::HI_HALF_MASK) >> 16);
					out_d.entry_build = 16'(a_q & rhp_pkg::LO_HALF_MASK);
					out_d.entry_uses = dec;
					out_d.entry_valid = 1'b1;
					out_d.parse_error = 1'b0;
					out_d.last_result = rem_q == RemW'(1);
					rem_d = rem_q - RemW'(1);
					pos_d = pos_q + PW'(8);
					state_d = (rem_q == RemW'(1)) ? rhp_pkg::ST_LOAD : rhp_pkg::ST_ENT_A;
				end
			end
			rhp_pkg::ST_FLAG: begin
				if (slot_free) begin
					out_vld_d = 1'b1;
					out_d = '0;
					out_d.parse_error = err_q;
					out_d.last_result = 1'b1;
					err_d = 1'b0;
					state_d = rhp_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = rhp_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhp_pkg::ST_LOAD;
			err_q <= 1'b0;
			out_vld_q <= 1'b0;
			rd_vld_q <= 1'b0;
			rem_q <= '0;
		end else begin
			state_q <= state_d;
			err_q <= err_d;
			out_vld_q <= out_vld_d;
			rd_vld_q <= rd_en;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		size_q <= size_d;
		pos_q <= pos_d;
		found_q <= found_d;
		pad_q <= pad_d;
		cnt_q <= cnt_d;
		key_q <= key_d;
		a_q <= a_d;
		out_q <= out_d;
		if (rd_en) begin
			rd_pos_q <= rd_pos;
		end
	end

	assign result_valid = out_vld_q;
	assign result = out_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rhp_pkg::*;

	localparam int BUF_BYTES = BUFFER_BYTES_DEF;
	// Cycles to let the parse engine settle after the final entry of a buffer
	localparam int SETTLE_CYCLES = 32;
	// Length of the long receiver hold-off used to back up the request queue
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;
	logic byte_valid;
	logic byte_stall;
	rhp_in_t byte_req;
	logic result_valid;
	logic result_stall = 1'b0;
	rhp_out_t result;

	rich_header_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_req(byte_req),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Shadow of the block: byte store, fill level and the two signature registers
	logic [7:0] shadow_bytes [BUF_BYTES];
	int fill;
	logic [31:0] cur_end_sig;
	logic [31:0] cur_begin_sig;

	// Entries still owed by the block, oldest first
	rhp_out_t rich_entries_due[$];

	// Buffer under construction and the decoded entry words that go into it
	logic [7:0] stub_bytes[$];
	logic [31:0] entry_words[$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned items_stored;

	// Sender idling: bursts of random length separated by idle gaps bounded by gap_max
	int gap_max;
	int burst_left;

	// Receiver idling: percentage of stall runs, plus long hold-offs on request
	int stall_pct;
	int hold_asked;
	int hold_taken;
	int hold_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("** rich_header_parser_unit: FAILED **");
		$finish;
	end

	// Receiver stall pattern. A hold-off request wins over the random runs and is
	// counted down here, so the sender keeps running while results back up.
	always @(posedge clk) begin
		logic lvl;
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_asked;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			// Stall each cycle with probability stall_pct percent
			lvl = ($urandom_range(99) < stall_pct);
			if ($urandom_range(5) == 0 || !lvl)
				result_stall <= lvl;
			else
				result_stall <= result_stall | lvl;
		end
	end

	function automatic logic [31:0] word_at(input int p);
		if (p < 0 || p + 3 >= BUF_BYTES)
			return '0;
		return {shadow_bytes[p + 3], shadow_bytes[p + 2], shadow_bytes[p + 1], shadow_bytes[p]};
	endfunction

	// Store one accepted byte; on the last byte parse the kept buffer and queue
	// the entries (or the single empty/error result) that the block owes.
	task automatic decode_rich_byte(input logic [7:0] d, input logic l);
		int found;
		int padded;
		int count;
		int emit;
		int off;
		bit hit;
		logic [31:0] key;
		logic [31:0] id_word;
		rhp_out_t r;
		if (fill < BUF_BYTES) begin
			shadow_bytes[fill] = d;
			fill++;
			items_stored++;
		end
		if (!l)
			return;
		found = fill + 1;
		hit = 1'b0;
		padded = 0;
		key = '0;
		// First byte offset holding the end signature, any alignment
		for (int i = 0; i + 3 < fill; i++) begin
			if (word_at(i) == cur_end_sig) begin
				found = i;
				break;
			end
		end
		// Key word must lie inside the buffer and the begin word must fit below
		if (!(found > fill || found + 8 > fill || found < 4)) begin
			key = word_at(found + 4);
			for (int w = found - 4; w >= 4; w -= 4) begin
				if ((word_at(w) ^ key) == cur_begin_sig) begin
					hit = 1'b1;
					break;
				end
				padded++;
			end
		end
		fill = 0;
		r = '0;
		r.last_result = 1'b1;
		if (!hit) begin
			r.parse_error = 1'b1;
			rich_entries_due.push_back(r);
			return;
		end
		// Drop leading decoded-zero words, then floor to whole entries
		count = padded;
		off = found - padded * 4;
		for (int i = 0; i < padded; i++) begin
			if ((word_at(off) ^ key) != 32'd0)
				break;
			count--;
			off += 4;
		end
		count /= 2;
		if (count == 0) begin
			rich_entries_due.push_back(r);
			return;
		end
		emit = (count > MAX_RESULTS) ? MAX_RESULTS : count;
		// Entries count back from the end signature; an odd leftover word is lost
		off = found - count * 8;
		for (int k = 0; k < emit; k++) begin
			id_word = word_at(off) ^ key;
			r.entry_id = 16'((id_word & HI_HALF_MASK) >> 16);
			r.entry_build = 16'(id_word & LO_HALF_MASK);
			r.entry_uses = word_at(off + 4) ^ key;
			r.entry_valid = 1'b1;
			r.parse_error = 1'b0;
			r.last_result = (k == emit - 1);
			rich_entries_due.push_back(r);
			off += 8;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted result against the oldest entry owed
	always @(posedge clk) begin
		rhp_out_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			results_seen++;
			if (rich_entries_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, result);
				mismatches++;
			end else begin
				want = rich_entries_due.pop_front();
				check_field("entry_id", want.entry_id, result.entry_id);
				check_field("entry_build", want.entry_build, result.entry_build);
				check_field("entry_uses", want.entry_uses, result.entry_uses);
				check_field("entry_valid", want.entry_valid, result.entry_valid);
				check_field("parse_error", want.parse_error, result.parse_error);
				check_field("last_result", want.last_result, result.last_result);
			end
		end
	end

	// Offer one byte request and hold it until the block takes it
	task automatic push_byte(input logic [7:0] d, input logic l);
		if (gap_max != 0 && burst_left == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left != 0)
			burst_left--;
		byte_valid <= 1'b1;
		byte_req <= '{data_byte: d, last_byte: l};
		do
			@(posedge clk);
		while (byte_stall !== 1'b0);
		decode_rich_byte(d, l);
	endtask

	task automatic send_stub();
		foreach (stub_bytes[i])
			push_byte(stub_bytes[i], i == stub_bytes.size() - 1);
	endtask

	// Stop offering, wait for every owed result, then let the engine go idle
	task automatic drain();
		byte_valid <= 1'b0;
		while (rich_entries_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_END_SIG)
			cur_end_sig = value;
		else
			cur_begin_sig = value;
	endtask

	task automatic add_word(input logic [31:0] w);
		stub_bytes.push_back(w[7:0]);
		stub_bytes.push_back(w[15:8]);
		stub_bytes.push_back(w[23:16]);
		stub_bytes.push_back(w[31:24]);
	endtask

	task automatic add_random(input int n);
		repeat (n) stub_bytes.push_back(8'($urandom));
	endtask

	task automatic fill_entries(input int n);
		entry_words.delete();
		repeat (2 * n) entry_words.push_back($urandom);
	endtask

	// Lay out: filler, begin word, zero words, optional odd word, entries,
	// end signature, key, trailing filler. The begin word and all words up to the end signature are key-encoded.
	task automatic build_table(input int pre_len, input int n_zero, input bit odd_word,
			input int post_len, input logic [31:0] key);
		stub_bytes.delete();
		add_random(pre_len);
		add_word(cur_begin_sig ^ key);
		repeat (n_zero) add_word(key);
		if (odd_word)
			add_word(key ^ ($urandom | 32'd1));
		foreach (entry_words[i])
			add_word(entry_words[i] ^ key);
		add_word(cur_end_sig);
		add_word(key);
		add_random(post_len);
	endtask

	task automatic test_good_tables();
		// One entry, begin word at offset 4, key ends the buffer
		fill_entries(1);
		build_table(4, 0, 0, 0, $urandom);
		send_stub();
		// Empty table: begin word right below the end signature
		fill_entries(0);
		build_table(6, 0, 0, 3, $urandom);
		send_stub();
		// Only zero words between the signatures
		build_table(4, 3, 0, 2, $urandom);
		send_stub();
		// Odd word count: lowest leftover word dropped
		fill_entries(2);
		build_table(8, 0, 1, 1, $urandom);
		send_stub();
		// Leading zero words skipped, unaligned end offset
		fill_entries(3);
		build_table(5, 2, 0, 4, $urandom);
		send_stub();
		// Field extremes, zero key
		entry_words = '{32'hffff_ffff, 32'hffff_ffff, 32'h0000_ffff, 32'h0000_0000,
			32'hffff_0000, 32'h8000_0001};
		build_table(4, 0, 0, 0, 32'h0);
		send_stub();
		// Same words under an all-ones key
		build_table(7, 1, 1, 2, 32'hffff_ffff);
		send_stub();
		// Second end signature after the key: first one wins
		fill_entries(2);
		build_table(4, 0, 0, 0, $urandom);
		add_word(cur_end_sig);
		add_random(9);
		send_stub();
	endtask

	task automatic test_parse_errors();
		// No end signature
		stub_bytes.delete();
		add_random(16);
		send_stub();
		// End signature below offset 4
		stub_bytes.delete();
		add_random(2);
		add_word(cur_end_sig);
		add_word($urandom);
		add_random(8);
		send_stub();
		// End signature at offset 4 leaves no room for a begin word
		stub_bytes.delete();
		add_random(4);
		add_word(cur_end_sig);
		add_word($urandom);
		send_stub();
		// Key word cut short
		fill_entries(1);
		build_table(4, 0, 0, 0, $urandom);
		void'(stub_bytes.pop_back());
		send_stub();
		// No begin signature
		fill_entries(2);
		build_table(4, 0, 0, 0, $urandom);
		for (int i = 4; i < 8; i++)
			stub_bytes[i] = ~stub_bytes[i];
		send_stub();
		// Begin word only at offset 0, below the walk limit
		fill_entries(1);
		build_table(0, 0, 0, 3, $urandom);
		send_stub();
		// Buffers too short to hold a word
		push_byte(8'hff, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'ha5, 1'b1);
	endtask

	task automatic test_buffer_overflow();
		// Full store of entries, then bytes past the store that must be ignored
		fill_entries(30);
		build_table(4, 0, 0, 0, $urandom);
		add_random(12);
		send_stub();
	endtask

	task automatic test_signature_registers();
		cfg_write(REG_END_SIG, 32'h0);
		cfg_write(REG_BEGIN_SIG, 32'hffff_ffff);
		fill_entries(2);
		build_table(4, 1, 0, 2, $urandom);
		send_stub();
		stub_bytes.delete();
		add_random(12);
		send_stub();
		// Begin signature zero: a decoded zero word is itself a begin word
		cfg_write(REG_END_SIG, 32'hffff_ffff);
		cfg_write(REG_BEGIN_SIG, 32'h0);
		fill_entries(1);
		build_table(4, 1, 0, 0, $urandom);
		send_stub();
		cfg_write(REG_END_SIG, $urandom);
		cfg_write(REG_BEGIN_SIG, $urandom);
		fill_entries(2);
		build_table(6, 0, 1, 1, $urandom);
		send_stub();
		cfg_write(REG_END_SIG, END_SIG_RST);
		cfg_write(REG_BEGIN_SIG, BEGIN_SIG_RST);
	endtask

	task automatic test_backpressure();
		// Long receiver hold-off while tables keep arriving back to back
		gap_max = 0;
		stall_pct = 0;
		hold_asked++;
		repeat (2) begin
			fill_entries(4);
			build_table(4, 0, 0, 2, $urandom);
			send_stub();
		end
		// Sender waits for every owed entry before the next buffer
		drain();
		fill_entries(2);
		build_table(4, 0, 0, 0, $urandom);
		send_stub();
		drain();
	endtask

	task automatic test_random_stream();
		int unsigned items_goal;
		int unsigned results_goal;
		int buffers;
		int kind;
		int n;
		int pre_len;
		items_goal = items_stored + 60;
		results_goal = results_seen + 8;
		buffers = 0;
		while (items_stored < items_goal || results_seen < results_goal) begin
			// New idling phase every few buffers, sometimes with no idling at all
			if (buffers % 3 == 0) begin
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 80;
				endcase
				case ($urandom_range(2))
					0: gap_max = 0;
					1: gap_max = 3;
					default: gap_max = 8;
				endcase
			end
			// Occasionally move the signatures; stay mostly on the defaults
			if (buffers % 6 == 5) begin
				if ($urandom_range(1)) begin
					cfg_write(REG_END_SIG, $urandom);
					cfg_write(REG_BEGIN_SIG, $urandom);
				end else begin
					cfg_write(REG_END_SIG, END_SIG_RST);
					cfg_write(REG_BEGIN_SIG, BEGIN_SIG_RST);
				end
			end
			kind = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(7, 25) : $urandom_range(0, 6);
			pre_len = ($urandom_range(3) == 0) ? 4 : $urandom_range(4, 12);
			if (kind < 85) begin
				fill_entries(n);
				build_table(pre_len, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0,
					$urandom_range(1), $urandom_range(0, 6), $urandom);
				if (kind >= 70) begin
					// Break the table: truncate, flip a bit of the begin word, or flip a bit near the end
					case ($urandom_range(2))
						0: repeat ($urandom_range(1, 7)) void'(stub_bytes.pop_back());
						1: stub_bytes[pre_len + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
						default: stub_bytes[stub_bytes.size() - 8 - $urandom_range(3)] ^= 8'h10;
					endcase
				end else if ($urandom_range(19) == 0) begin
					// Run past the store end
					add_random(BUF_BYTES - stub_bytes.size() + $urandom_range(1, 20));
				end
			end else begin
				stub_bytes.delete();
				add_random($urandom_range(1, 40));
				if ($urandom_range(1))
					add_word(cur_end_sig);
				add_random($urandom_range(0, 8));
			end
			send_stub();
			buffers++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_END_SIG;
		cfg_wdata <= '0;
		byte_valid <= 1'b0;
		byte_req <= '0;
		fill = 0;
		cur_end_sig = END_SIG_RST;
		cur_begin_sig = BEGIN_SIG_RST;
		mismatches = 0;
		results_seen = 0;
		items_stored = 0;
		gap_max = 0;
		burst_left = 0;
		stall_pct = 0;
		hold_asked = 0;
		hold_taken = 0;
		hold_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_tables();
		gap_max = 4;
		stall_pct = 30;
		test_parse_errors();
		test_buffer_overflow();
		test_signature_registers();
		test_backpressure();
		test_random_stream();

		drain();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && rich_entries_due.size() == 0)
			$display("** rich_header_parser_unit: PASSED **");
		else
			$display("** rich_header_parser_unit: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
src/rhp_pkg.sv
src/rhp_front.sv
src/rhp_queue.sv
src/rhp_back.sv
src/rich_header_parser_unit.sv
tb/tb_top.sv
